// File: src/a2u_pkg.sv
// Shared types, constants and character decode for the ASCII to u64 parser.
package a2u_pkg;

    localparam int MAX_LEN = 4095;
    localparam int POS_W   = $clog2(MAX_LEN + 2);
    localparam int END_W   = 12;
    localparam int VAL_W   = 64;
    localparam int BASE_W  = 6;
    localparam int DIG_W   = 6;
    localparam int PROD_W  = VAL_W + BASE_W;

    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(16);
    localparam logic [BASE_W-1:0] BASE_AUTO  = BASE_W'(0);
    localparam logic [BASE_W-1:0] BASE_OCT   = BASE_W'(8);
    localparam logic [BASE_W-1:0] BASE_DEC   = BASE_W'(10);
    localparam logic [BASE_W-1:0] BASE_HEX   = BASE_W'(16);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    typedef enum logic [2:0] {
        PH_DONE,
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_HEXPFX,
        PH_DIGITS
    } phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       start_req;
    } char_beat_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [END_W-1:0] end_index;
        logic             overflowed;
        logic             found_digits;
    } res_beat_t;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UP_A && c <= CH_UP_Z)
            || (c >= CH_LO_A && c <= CH_LO_Z);
    endfunction

    // Digit value of 0-9, A-Z, a-z; don't care for anything else.
    function automatic logic [DIG_W-1:0] dig_val(input logic [7:0] c);
        logic [7:0] d;
        if (c >= CH_ZERO && c <= CH_NINE)
            d = c - CH_ZERO;
        else if (c >= CH_UP_A && c <= CH_UP_Z)
            d = c - (CH_UP_A - 8'd10);
        else if (c >= CH_LO_A && c <= CH_LO_Z)
            d = c - (CH_LO_A - 8'd10);
        else
            d = 8'd0;
        return d[DIG_W-1:0];
    endfunction

endpackage

// File: src/ascii_to_u64_parser.sv
// Top level of the ASCII to unsigned 64-bit parser.
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------------
//  char      | char_valid, char_stall | ch, start_req
//  result    | res_valid, res_stall   | value, end_index, overflowed, found_digits
//  config    | cfg_we                 | cfg_data (number_base)
//
// One character beat is taken per cycle while char_stall is low; the throughput limit
// is the accumulator loop, one 64x6 multiply-add with overflow check per clock.
// A result is offered after its ending beat passes the input and result registers.
// Reset clears all parse state, sets number_base to 16 and leaves the parser
// waiting for a start beat. A stalled result holds the pipeline; an empty input register
// still takes one more beat before char_stall rises.
module ascii_to_u64_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [a2u_pkg::BASE_W-1:0] cfg_data,
    input  logic                       char_valid,
    output logic                       char_stall,
    input  logic [7:0]                 ch,
    input  logic                       start_req,
    output logic                       res_valid,
    input  logic                       res_stall,
    output logic [a2u_pkg::VAL_W-1:0]  value,
    output logic [a2u_pkg::END_W-1:0]  end_index,
    output logic                       overflowed,
    output logic                       found_digits
);
    import a2u_pkg::*;

    char_beat_t char_in;
    char_beat_t beat;
    logic       beat_vld;
    logic       busy;
    logic       advance;
    logic       fire;
    logic       core_vld;
    res_beat_t  core_res;
    res_beat_t  res_out;

    assign char_in.ch        = ch;
    assign char_in.start_req = start_req;

    // Advance the held beat whenever the result register can take a new result.
    assign advance = !busy;
    assign fire    = beat_vld && advance;

    a2u_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_in    (char_in),
        .advance    (advance),
        .beat_vld   (beat_vld),
        .beat       (beat)
    );

    a2u_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .fire     (fire),
        .beat     (beat),
        .res_vld  (core_vld),
        .res      (core_res)
    );

    a2u_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_in_vld (core_vld),
        .res_in     (core_res),
        .busy       (busy),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_out    (res_out)
    );

    assign value        = res_out.value;
    assign end_index    = res_out.end_index;
    assign overflowed   = res_out.overflowed;
    assign found_digits = res_out.found_digits;

endmodule

// File: src/a2u_in_stage.sv
// Input register for character beats.
module a2u_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_stall,
    input  a2u_pkg::char_beat_t char_in,
    input  logic                advance,
    output logic                beat_vld,
    output a2u_pkg::char_beat_t beat
);
    import a2u_pkg::*;

    logic       vld_reg;
    logic       vld_next;
    char_beat_t beat_reg;
    logic       take;

    // Hold the input only while a held beat cannot advance.
    assign char_stall = vld_reg && !advance;
    assign take       = char_valid && !char_stall;

    always_comb
    begin
        if (take)
            vld_next = 1'b1;
        else if (advance)
            vld_next = 1'b0;
        else
            vld_next = vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            beat_reg <= char_in;
    end

    assign beat_vld = vld_reg;
    assign beat     = beat_reg;

endmodule

// File: src/a2u_core.sv
// Parse state and one-character step: sign, prefix, digit multiply-add, result.
module a2u_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [a2u_pkg::BASE_W-1:0] cfg_data,
    input  logic                       fire,
    input  a2u_pkg::char_beat_t        beat,
    output logic                       res_vld,
    output a2u_pkg::res_beat_t         res
);
    import a2u_pkg::*;

    logic [BASE_W-1:0] nbase_reg;
    logic [VAL_W-1:0]  acc_reg, acc_next;
    phase_t            ph_reg, ph_next;
    logic              neg_reg, neg_next;
    logic              seen_reg, seen_next;
    logic              ovf_reg, ovf_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BASE_W-1:0] base_reg, base_next;

    logic [VAL_W-1:0]  acc_cur;
    phase_t            ph_cur;
    logic              neg_cur, seen_cur, ovf_cur;
    logic [POS_W-1:0]  pos_cur;
    logic [BASE_W-1:0] base_cur;

    logic [7:0]        c;
    logic [DIG_W-1:0]  dv;
    logic              alnum;
    logic [BASE_W-1:0] tb_raw, tb;
    logic [PROD_W-1:0] prod;
    logic              dig_ok;
    logic              do_take, do_emit, idle_step;
    logic              emit_seen;
    logic [POS_W-1:0]  emit_pos, end_clamp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nbase_reg <= BASE_RESET;
        else if (cfg_we)
            nbase_reg <= cfg_data;
    end

    // A start beat restarts the state before the step looks at it.
    assign c        = beat.ch;
    assign acc_cur  = beat.start_req ? '0 : acc_reg;
    assign ph_cur   = beat.start_req ? PH_LEAD : ph_reg;
    assign neg_cur  = beat.start_req ? 1'b0 : neg_reg;
    assign seen_cur = beat.start_req ? 1'b0 : seen_reg;
    assign ovf_cur  = beat.start_req ? 1'b0 : ovf_reg;
    assign pos_cur  = beat.start_req ? '0 : pos_reg;
    assign base_cur = beat.start_req ? nbase_reg : base_reg;

    assign dv    = dig_val(c);
    assign alnum = is_alnum(c);

    always_comb
    begin
        if (ph_cur == PH_ZERO && base_cur == BASE_AUTO)
            tb_raw = BASE_OCT;
        else
            tb_raw = base_cur;
    end

    assign tb     = (tb_raw == BASE_AUTO) ? BASE_DEC : tb_raw;
    assign prod   = PROD_W'(acc_cur) * PROD_W'(tb) + PROD_W'(dv);
    assign dig_ok = alnum && (dv < tb);

    always_comb
    begin
        acc_next  = acc_cur;
        ph_next   = ph_cur;
        neg_next  = neg_cur;
        seen_next = seen_cur;
        ovf_next  = ovf_cur;
        base_next = base_cur;
        do_take   = 1'b0;
        do_emit   = 1'b0;
        emit_seen = seen_cur;
        emit_pos  = pos_cur;
        idle_step = 1'b0;

        case (ph_cur)
            PH_LEAD:
            begin
                if (c == CH_SPACE)
                    ph_next = PH_LEAD;
                else if (c == CH_MINUS)
                begin
                    neg_next = 1'b1;
                    ph_next  = PH_SIGNED;
                end
                else if (c == CH_PLUS)
                    ph_next = PH_SIGNED;
                else if (c == CH_ZERO && (base_cur == BASE_AUTO || base_cur == BASE_HEX))
                    ph_next = PH_ZERO;
                else
                    do_take = 1'b1;
            end
            PH_SIGNED:
            begin
                if (c == CH_ZERO && (base_cur == BASE_AUTO || base_cur == BASE_HEX))
                    ph_next = PH_ZERO;
                else
                    do_take = 1'b1;
            end
            PH_ZERO:
            begin
                if (c == CH_LO_X || c == CH_UP_X)
                begin
                    base_next = BASE_HEX;
                    ph_next   = PH_HEXPFX;
                end
                else
                begin
                    // The leading zero counts as a digit.
                    seen_next = 1'b1;
                    emit_seen = 1'b1;
                    do_take   = 1'b1;
                end
            end
            PH_HEXPFX:
            begin
                if (alnum && dv < DIG_W'(16))
                    do_take = 1'b1;
                else
                begin
                    // Bare prefix: report the zero, end at the 'x'.
                    seen_next = 1'b1;
                    emit_seen = 1'b1;
                    do_emit   = 1'b1;
                    emit_pos  = pos_cur - POS_W'(1);
                end
            end
            PH_DIGITS:
                do_take = 1'b1;
            default:
                idle_step = 1'b1;
        endcase

        if (do_take)
        begin
            base_next = tb;
            if (!dig_ok)
                do_emit = 1'b1;
            else
            begin
                if (ovf_cur || (|prod[PROD_W-1:VAL_W]))
                    ovf_next = 1'b1;
                else
                    acc_next = prod[VAL_W-1:0];
                seen_next = 1'b1;
                ph_next   = PH_DIGITS;
            end
        end

        if (do_emit)
            ph_next = PH_DONE;
    end

    always_comb
    begin
        if (idle_step)
            pos_next = pos_reg;
        else if (pos_cur <= POS_W'(MAX_LEN))
            pos_next = pos_cur + POS_W'(1);
        else
            pos_next = pos_cur;
    end

    assign end_clamp = (emit_pos > POS_W'(MAX_LEN)) ? POS_W'(MAX_LEN) : emit_pos;

    always_comb
    begin
        if (ovf_cur)
            res.value = '1;
        else if (emit_seen)
            res.value = neg_cur ? (VAL_W'(0) - acc_cur) : acc_cur;
        else
            res.value = '0;
        res.end_index    = emit_seen ? END_W'(end_clamp) : '0;
        res.overflowed   = ovf_cur;
        res.found_digits = emit_seen;
    end

    assign res_vld = fire && do_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            ph_reg   <= PH_DONE;
            neg_reg  <= 1'b0;
            seen_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            pos_reg  <= '0;
            base_reg <= '0;
        end
        else if (fire)
        begin
            acc_reg  <= acc_next;
            ph_reg   <= ph_next;
            neg_reg  <= neg_next;
            seen_reg <= seen_next;
            ovf_reg  <= ovf_next;
            pos_reg  <= pos_next;
            base_reg <= base_next;
        end
    end

endmodule

// File: src/a2u_out_stage.sv
// Result register with stall hold.
module a2u_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_in_vld,
    input  a2u_pkg::res_beat_t res_in,
    output logic               busy,
    output logic               res_valid,
    input  logic               res_stall,
    output a2u_pkg::res_beat_t res_out
);
    import a2u_pkg::*;

    logic      vld_reg, vld_next;
    res_beat_t res_reg;

    assign busy = vld_reg && res_stall;

    always_comb
    begin
        if (res_in_vld)
            vld_next = 1'b1;
        else if (!res_stall)
            vld_next = 1'b0;
        else
            vld_next = vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_in_vld)
            res_reg <= res_in;
    end

    assign res_valid = vld_reg;
    assign res_out   = res_reg;

endmodule

// File: src/a2u_chk.sv
// Port-level checker for the parser, bound to the top level.
module a2u_chk (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       char_valid,
    input logic                       char_stall,
    input logic                       res_valid,
    input logic                       res_stall,
    input logic [a2u_pkg::VAL_W-1:0]  value,
    input logic [a2u_pkg::END_W-1:0]  end_index,
    input logic                       overflowed,
    input logic                       found_digits
);
    import a2u_pkg::*;

    // Hold a stalled result beat.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(value) && $stable(end_index))
        else $error("stalled result beat changed");

    // Saturate on overflow, and overflow implies digits.
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && overflowed |-> found_digits && (value == '1))
        else $error("overflow result not saturated");

    // Report zero with no digits.
    a_nodig: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !found_digits |-> (value == '0) && (end_index == '0) && !overflowed)
        else $error("empty parse result not zero");

    // A new result follows an accepted character beat, through the input and result registers.
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(char_valid && !char_stall, 2))
        else $error("result without an accepted character beat");

endmodule

bind ascii_to_u64_parser a2u_chk u_a2u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .value        (value),
    .end_index    (end_index),
    .overflowed   (overflowed),
    .found_digits (found_digits)
);
